[rtl/core/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared codes and types for the sorted key/value table: operation and status
// codes, and the control word broadcast to the row of storage cells.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;
    localparam int WORD_BITS   = 64;

    typedef enum logic [OP_BITS-1:0] {
        OP_UPSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_LIST     = 2'd2,
        OP_RESERVED = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE   = 3'd0,
        ST_FULL   = 3'd1,
        ST_ABSENT = 3'd2,
        ST_LISTED = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    // what every cell does in the current cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_REMOVE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     found;   // key present in the row (remove step)
    } t_cell_ctl;

endpackage

[rtl/core/skvt_if.sv]
// ----------------------------------------------------------------------------
// skvt_if
// Valid/ready channel interfaces: command channel into the table and result
// channel out of it.
// ----------------------------------------------------------------------------
interface skvt_in_if import skvt_pkg::*; #(
    parameter int KEY_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic [OP_BITS-1:0]         operation;
    logic signed [KEY_BITS-1:0] key;
    logic [WORD_BITS-1:0]       low_word;
    logic [WORD_BITS-1:0]       high_word;

    modport source (output valid, output operation, output key, output low_word,
                    output high_word, input ready);
    modport sink   (input valid, input operation, input key, input low_word,
                    input high_word, output ready);
endinterface

interface skvt_out_if import skvt_pkg::*; #(
    parameter int KEY_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic [STATUS_BITS-1:0]     status;
    logic signed [KEY_BITS-1:0] entry_key;
    logic [WORD_BITS-1:0]       entry_low;
    logic [WORD_BITS-1:0]       entry_high;
    logic                       last;

    modport source (output valid, output status, output entry_key, output entry_low,
                    output entry_high, output last, input ready);
    modport sink   (input valid, input status, input entry_key, input entry_low,
                    input entry_high, input last, output ready);
endinterface

[rtl/core/skvt_cell.sv]
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted row. Compares its key with the command key and, as
// told by the control word, holds or takes its right neighbour (remove, list
// rotation), cell 0 (list tail), left neighbour (insert shift) or new entry.
// ----------------------------------------------------------------------------
module skvt_cell import skvt_pkg::*; #(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 16,
    parameter int IDX      = 0
) (
    input  logic                             i_clk,
    input  t_cell_ctl                        i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]    i_count,
    input  logic signed [KEY_BITS-1:0]       i_key,
    input  logic [WORD_BITS-1:0]             i_lo,
    input  logic [WORD_BITS-1:0]             i_hi,
    input  logic                             i_left_lt,
    input  logic signed [KEY_BITS-1:0]       i_left_key,
    input  logic [WORD_BITS-1:0]             i_left_lo,
    input  logic [WORD_BITS-1:0]             i_left_hi,
    input  logic signed [KEY_BITS-1:0]       i_right_key,
    input  logic [WORD_BITS-1:0]             i_right_lo,
    input  logic [WORD_BITS-1:0]             i_right_hi,
    input  logic signed [KEY_BITS-1:0]       i_wrap_key,
    input  logic [WORD_BITS-1:0]             i_wrap_lo,
    input  logic [WORD_BITS-1:0]             i_wrap_hi,
    output logic signed [KEY_BITS-1:0]       o_key,
    output logic [WORD_BITS-1:0]             o_lo,
    output logic [WORD_BITS-1:0]             o_hi,
    output logic                             o_lt,
    output logic                             o_eq
);
    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [WORD_BITS-1:0]       r_lo, n_lo;
    logic [WORD_BITS-1:0]       r_hi, n_hi;
    logic                       w_valid;

    assign w_valid = IDX_C < i_count;
    assign o_lt    = w_valid && (r_key < i_key);
    assign o_eq    = w_valid && (r_key == i_key);

    always_comb begin
        n_key = r_key;
        n_lo  = r_lo;
        n_hi  = r_hi;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_REMOVE: begin
                // sorted and unique: every slot at or past the match has key >= it
                if (i_ctl.found && w_valid && (r_key >= i_key)) begin
                    n_key = i_right_key;
                    n_lo  = i_right_lo;
                    n_hi  = i_right_hi;
                end
            end
            CELL_INSERT: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_key = i_key;
                        n_lo  = i_lo;
                        n_hi  = i_hi;
                    end else if (IDX_C <= i_count) begin
                        n_key = i_left_key;
                        n_lo  = i_left_lo;
                        n_hi  = i_left_hi;
                    end
                end
            end
            CELL_ROTATE: begin
                if (IDX_P1 == i_count) begin
                    n_key = i_wrap_key;
                    n_lo  = i_wrap_lo;
                    n_hi  = i_wrap_hi;
                end else if (IDX_P1 < i_count) begin
                    n_key = i_right_key;
                    n_lo  = i_right_lo;
                    n_hi  = i_right_hi;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

    assign o_key = r_key;
    assign o_lo  = r_lo;
    assign o_hi  = r_hi;

endmodule

[rtl/core/sorted_key_value_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Bounded table held in ascending signed-key order in a row of cells.
//
// i_cmd carries one command per transaction: upsert, delete or list. o_rsp
// returns the results; last marks the final result of a command. Upsert and
// delete give one result, list one per entry (or one "table empty").
// A command is taken while the sequencer is idle or handing its result to the
// output register. Delete or full upsert: remove step, then result step.
// Upsert: remove step, ordered-insert step, result step. Empty list or unused
// code: result step only. List of n entries: one entry per cycle while o_rsp
// is not stalled, the row rotating its contents through cell 0 and back into
// the tail, so after a list the order is unchanged.
// The output register separates the sides: while o_rsp is stalled, a pending
// single result waits and a list pauses its rotation; no result is lost.
// Reset (synchronous, active low) empties the table by clearing the entry
// count; cell contents are not cleared and never read beyond the count.
// ----------------------------------------------------------------------------
module sorted_key_value_table import skvt_pkg::*; #(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skvt_in_if.sink    i_cmd,
    skvt_out_if.source o_rsp
);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REMOVE = 5'b00010,
        S_INSERT = 5'b00100,
        S_EMIT   = 5'b01000,
        S_LIST   = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [IW-1:0]              r_idx, n_idx;
    t_op                        r_op, n_op;
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [WORD_BITS-1:0]       r_lo, n_lo;
    logic [WORD_BITS-1:0]       r_hi, n_hi;
    t_status                    r_status, n_status;

    logic                       r_out_valid, n_out_valid;
    t_status                    r_out_status, n_out_status;
    logic signed [KEY_BITS-1:0] r_out_key, n_out_key;
    logic [WORD_BITS-1:0]       r_out_lo, n_out_lo;
    logic [WORD_BITS-1:0]       r_out_hi, n_out_hi;
    logic                       r_out_last, n_out_last;

    logic signed [KEY_BITS-1:0] c_key [CAPACITY];
    logic [WORD_BITS-1:0]       c_lo  [CAPACITY];
    logic [WORD_BITS-1:0]       c_hi  [CAPACITY];
    logic [CAPACITY-1:0]        c_lt;
    logic [CAPACITY-1:0]        c_eq;

    t_cell_ctl                  w_ctl;
    logic                       w_found;
    logic                       w_out_free;
    logic                       w_accept;
    logic                       w_list_last;

    assign w_found     = |c_eq;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE) || ((r_state == S_EMIT) && w_out_free);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_list_last = ({1'b0, r_idx} + ONE_C) == r_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_op         = r_op;
        n_key        = r_key;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_lo     = r_out_lo;
        n_out_hi     = r_out_hi;
        n_out_last   = r_out_last;
        w_ctl.op     = CELL_HOLD;
        w_ctl.found  = w_found;

        unique case (r_state)
            S_IDLE: begin
            end
            S_REMOVE: begin
                w_ctl.op = CELL_REMOVE;
                n_count  = r_count - CW'(w_found);
                n_state  = S_EMIT;
                if (r_op == OP_UPSERT) begin
                    if ((r_count - CW'(w_found)) == CAP_C) begin
                        n_status = ST_FULL;
                    end else begin
                        n_state = S_INSERT;
                    end
                end else begin
                    n_status = w_found ? ST_DONE : ST_ABSENT;
                end
            end
            S_INSERT: begin
                w_ctl.op = CELL_INSERT;
                n_count  = r_count + ONE_C;
                n_status = ST_DONE;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_key    = '0;
                    n_out_lo     = '0;
                    n_out_hi     = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    w_ctl.op     = CELL_ROTATE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_LISTED;
                    n_out_key    = c_key[0];
                    n_out_lo     = c_lo[0];
                    n_out_hi     = c_hi[0];
                    n_out_last   = w_list_last;
                    n_idx        = r_idx + IW'(1);
                    if (w_list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new command overrides the idle transition out of the result step
        if (w_accept) begin
            n_op  = t_op'(i_cmd.operation);
            n_key = i_cmd.key;
            n_lo  = i_cmd.low_word;
            n_hi  = i_cmd.high_word;
            n_idx = '0;
            unique case (t_op'(i_cmd.operation))
                OP_UPSERT, OP_DELETE: n_state = S_REMOVE;
                OP_LIST: begin
                    if (n_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_LIST;
                    end
                end
                OP_RESERVED: begin
                    n_status = ST_DONE;
                    n_state  = S_EMIT;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_op         <= n_op;
        r_key        <= n_key;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_lo     <= n_out_lo;
        r_out_hi     <= n_out_hi;
        r_out_last   <= n_out_last;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                       w_left_lt;
            logic signed [KEY_BITS-1:0] w_left_key, w_right_key;
            logic [WORD_BITS-1:0]       w_left_lo, w_left_hi, w_right_lo, w_right_hi;

            if (gi == 0) begin : g_head
                assign w_left_lt  = 1'b1;
                assign w_left_key = c_key[gi];
                assign w_left_lo  = c_lo[gi];
                assign w_left_hi  = c_hi[gi];
            end else begin : g_body
                assign w_left_lt  = c_lt[gi-1];
                assign w_left_key = c_key[gi-1];
                assign w_left_lo  = c_lo[gi-1];
                assign w_left_hi  = c_hi[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right_key = c_key[gi];
                assign w_right_lo  = c_lo[gi];
                assign w_right_hi  = c_hi[gi];
            end else begin : g_next
                assign w_right_key = c_key[gi+1];
                assign w_right_lo  = c_lo[gi+1];
                assign w_right_hi  = c_hi[gi+1];
            end

            skvt_cell #(
                .CAPACITY (CAPACITY),
                .KEY_BITS (KEY_BITS),
                .IDX      (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_count     (r_count),
                .i_key       (r_key),
                .i_lo        (r_lo),
                .i_hi        (r_hi),
                .i_left_lt   (w_left_lt),
                .i_left_key  (w_left_key),
                .i_left_lo   (w_left_lo),
                .i_left_hi   (w_left_hi),
                .i_right_key (w_right_key),
                .i_right_lo  (w_right_lo),
                .i_right_hi  (w_right_hi),
                .i_wrap_key  (c_key[0]),
                .i_wrap_lo   (c_lo[0]),
                .i_wrap_hi   (c_hi[0]),
                .o_key       (c_key[gi]),
                .o_lo        (c_lo[gi]),
                .o_hi        (c_hi[gi]),
                .o_lt        (c_lt[gi]),
                .o_eq        (c_eq[gi])
            );
        end
    endgenerate

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.entry_key  = r_out_key;
    assign o_rsp.entry_low  = r_out_lo;
    assign o_rsp.entry_high = r_out_hi;
    assign o_rsp.last       = r_out_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count beyond capacity");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) && w_found |=> r_count == $past(r_count) - ONE_C)
        else $error("remove step did not drop the count");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_LISTED) |-> r_out_last)
        else $error("single result without last");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && (r_count >= CW'(2)) |-> c_key[0] < c_key[1])
        else $error("row out of key order");

endmodule
